/* hdl/tqle_pkg.sv */
// Shared types, constants and helper functions of the tabular Q-learning engine.
// Used by tqle_scan, tqle_arith and the top level in this folder; depends on nothing else.
package tqle_pkg;

  localparam int NUM_STATES  = 1024;
  localparam int NUM_ACTIONS = 8;

  localparam int STATE_W = $clog2(NUM_STATES);
  localparam int ACT_W   = $clog2(NUM_ACTIONS);
  localparam int ADDR_W  = STATE_W + ACT_W;
  localparam int DEPTH   = NUM_STATES * NUM_ACTIONS;
  localparam int CNT_W   = $clog2(NUM_ACTIONS + 1);

  localparam int Q_W     = 32;
  localparam int FR_W    = 17;
  localparam int AU_W    = 4;
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 3;
  localparam int U_W     = 16;
  localparam int RACT_W  = 3;
  localparam int SIDX_W  = 10;
  localparam int AIDX_W  = 3;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 2;

  localparam logic [FR_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic [FR_W-1:0] RST_DISCOUNT = 17'd58982;
  localparam logic [FR_W-1:0] RST_LR_INIT  = 17'd6554;
  localparam logic [FR_W-1:0] RST_DECAY    = 17'd0;
  localparam logic [FR_W-1:0] RST_EPS_INIT = 17'd65536;
  localparam logic [FR_W-1:0] RST_EPS_FIN  = 17'd0;
  localparam logic [AU_W-1:0] RST_ACTIONS  = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_UPDATE  = 2'd0,
    CMD_CHOOSE  = 2'd1,
    CMD_DECAY   = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_DISCOUNT = 3'd0,
    CFG_LR_INIT  = 3'd1,
    CFG_DECAY    = 3'd2,
    CFG_EPS_INIT = 3'd3,
    CFG_EPS_FIN  = 3'd4,
    CFG_ACTIONS  = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SETTLE,
    S_OLD,
    S_MUL_D,
    S_TGT,
    S_MUL_L,
    S_SUM,
    S_DEC_MUL,
    S_DEC_ADD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic ld_disc;
    logic ld_tgt;
    logic ld_mul;
    logic ld_sum;
    logic dec_mul;
    logic dec_add;
    logic restart;
  } arith_ctrl_t;

  function automatic logic [FR_W-1:0] frac(input logic [FR_W-1:0] v);
    frac = (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  function automatic logic [CNT_W-1:0] used_actions(input logic [AU_W-1:0] au);
    if (au == '0) begin
      used_actions = CNT_W'(1);
    end else if (int'(au) > NUM_ACTIONS) begin
      used_actions = CNT_W'(NUM_ACTIONS);
    end else begin
      used_actions = CNT_W'(au);
    end
  endfunction

  function automatic logic [ACT_W-1:0] mod_action(input logic [RACT_W-1:0] ract,
                                                  input logic [CNT_W-1:0]  n);
    logic [CNT_W+RACT_W-1:0] r;
    r = (CNT_W+RACT_W)'(ract);
    for (int i = 0; i < (1 << RACT_W); i++) begin
      if (r >= (CNT_W+RACT_W)'(n)) begin
        r = r - (CNT_W+RACT_W)'(n);
      end
    end
    mod_action = ACT_W'(r);
  endfunction

endpackage

/* hdl/tqle_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module tqle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/tqle_scan.sv */
// Running maximum over one Q table row, fed one entry per cycle from the RAM.
// Depends on tqle_pkg.
module tqle_scan (
  input  logic                                clk,
  input  logic                                vld,
  input  logic [tqle_pkg::ACT_W-1:0]          col,
  input  logic signed [tqle_pkg::Q_W-1:0]     rdata,
  output logic signed [tqle_pkg::Q_W-1:0]     best,
  output logic [tqle_pkg::ACT_W-1:0]          best_col
);
  import tqle_pkg::*;

  logic signed [Q_W-1:0] best_r;
  logic [ACT_W-1:0]      best_col_r;

  // The first column always loads; later ones only when strictly larger.
  always_ff @(posedge clk) begin
    if (vld && (col == '0 || rdata > best_r)) begin
      best_r     <= rdata;
      best_col_r <= col;
    end
  end

  assign best     = best_r;
  assign best_col = best_col_r;

endmodule

/* hdl/tqle_arith.sv */
// Fixed-point update and decay arithmetic, plus the epsilon and learning rate state.
// Depends on tqle_pkg.
module tqle_arith (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tqle_pkg::arith_ctrl_t              ctrl,
  input  logic [tqle_pkg::FR_W-1:0]          discount,
  input  logic [tqle_pkg::FR_W-1:0]          lr_init,
  input  logic [tqle_pkg::FR_W-1:0]          decay,
  input  logic [tqle_pkg::FR_W-1:0]          eps_init,
  input  logic [tqle_pkg::FR_W-1:0]          eps_final,
  input  logic signed [tqle_pkg::Q_W-1:0]    best,
  input  logic signed [tqle_pkg::Q_W-1:0]    old_q,
  input  logic signed [tqle_pkg::Q_W-1:0]    reward,
  output logic [tqle_pkg::FR_W-1:0]          eps_now,
  output logic [tqle_pkg::FR_W-1:0]          lr_now,
  output logic signed [tqle_pkg::Q_W-1:0]    new_q,
  output logic                               sat
);
  import tqle_pkg::*;

  logic signed [Q_W-1:0]  old_r;
  logic signed [49:0]     p1_r;
  logic signed [33:0]     tgt_r;
  logic signed [49:0]     p2_r;
  logic signed [51:0]     p3_r;
  logic signed [Q_W-1:0]  new_q_r;
  logic                   sat_r;
  logic signed [35:0]     pe_r;
  logic [33:0]            pl_r;
  logic [FR_W-1:0]        eps_r;
  logic [FR_W-1:0]        lr_r;

  logic signed [17:0]     disc_s;
  logic signed [17:0]     lr_s;
  logic signed [17:0]     oml_s;
  logic signed [17:0]     f_s;
  logic [FR_W-1:0]        f_u;
  logic signed [17:0]     diff_s;
  logic signed [49:0]     t1;
  logic signed [33:0]     tgt_nxt;
  logic signed [52:0]     sum;
  logic signed [36:0]     v;
  logic                   sat_nxt;
  logic signed [Q_W-1:0]  new_q_nxt;
  logic signed [35:0]     te;
  logic signed [19:0]     eps_wide;
  logic [FR_W-1:0]        eps_nxt;
  logic [34:0]            tl;
  logic [FR_W-1:0]        lr_nxt;

  always_comb begin
    disc_s  = $signed({1'b0, discount});
    lr_s    = $signed({1'b0, lr_r});
    oml_s   = $signed({1'b0, ONE_Q16 - lr_r});
    f_u     = ONE_Q16 - decay;
    f_s     = $signed({1'b0, f_u});
    diff_s  = $signed({1'b0, eps_r}) - $signed({1'b0, eps_final});

    // Rounding adds one half and shifts arithmetically: ties go upward.
    t1      = p1_r + 50'sd32768;
    tgt_nxt = $signed({{2{reward[Q_W-1]}}, reward}) + $signed(t1[49:16]);

    sum     = $signed({{3{p2_r[49]}}, p2_r}) + $signed({p3_r[51], p3_r}) + 53'sd32768;
    v       = $signed(sum[52:16]);
    sat_nxt = (v[36:31] != '0) && (v[36:31] != '1);
    if (!sat_nxt) begin
      new_q_nxt = v[Q_W-1:0];
    end else if (v[36]) begin
      new_q_nxt = $signed({1'b1, {(Q_W-1){1'b0}}});
    end else begin
      new_q_nxt = $signed({1'b0, {(Q_W-1){1'b1}}});
    end

    te       = pe_r + 36'sd32768;
    eps_wide = $signed({3'b000, eps_final}) + $signed(te[35:16]);
    eps_nxt  = eps_wide[FR_W-1:0];
    tl       = {1'b0, pl_r} + 35'd32768;
    lr_nxt   = tl[32:16];
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_disc) begin
      p1_r  <= disc_s * best;
      old_r <= old_q;
    end
    if (ctrl.ld_tgt) begin
      tgt_r <= tgt_nxt;
    end
    if (ctrl.ld_mul) begin
      p2_r <= oml_s * old_r;
      p3_r <= lr_s * tgt_r;
    end
    if (ctrl.ld_sum) begin
      new_q_r <= new_q_nxt;
      sat_r   <= sat_nxt;
    end
    if (ctrl.dec_mul) begin
      pe_r <= f_s * diff_s;
      pl_r <= f_u * lr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= RST_EPS_INIT;
      lr_r  <= RST_LR_INIT;
    end else if (ctrl.restart) begin
      eps_r <= eps_init;
      lr_r  <= lr_init;
    end else if (ctrl.dec_add) begin
      eps_r <= eps_nxt;
      lr_r  <= lr_nxt;
    end
  end

  assign eps_now = eps_r;
  assign lr_now  = lr_r;
  assign new_q   = new_q_r;
  assign sat     = sat_r;

endmodule

/* hdl/tabular_q_learning_engine_unit.sv */
// Top level of the tabular Q-learning engine: request sequencer, Q table RAM,
// configuration registers and output register. Depends on tqle_pkg, tqle_ram,
// tqle_scan and tqle_arith.
//
// The Q table sits in one RAM with a single read port, so a row is scanned one
// entry per cycle. An update scans the used entries of the next row, reads the
// old entry and then runs the discount, target, learning-rate and sum steps; a
// choose scans its row and settles; a decay runs a multiply and an add step; a
// restart goes straight to the output stage. The result is loaded into the
// output register once that register is free, and the next request is taken in
// the cycle after the load. After reset the block writes zeros to all 8192 table
// entries before it takes its first request; configuration writes are taken
// during that time. A new request is accepted while the previous result still waits on the output.
module tabular_q_learning_engine_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // state_index[9:0], action[12:10], reward[44:13], next_row[54:45],
  // random_u[70:55], random_action[73:71], zero pad up to bit 79
  input  logic [tqle_pkg::IN_TDATA_W-1:0]       in_tdata,
  // command[1:0]
  input  logic [tqle_pkg::CMD_W-1:0]            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // chosen_action[2:0], row_max[34:3], new_q[66:35], zero pad up to bit 71
  output logic [tqle_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // explored[0], saturated[1]
  output logic [tqle_pkg::OUT_TUSER_W-1:0]      out_tuser,
  input  logic                                  cfg_we,
  input  logic [tqle_pkg::IDX_W-1:0]            cfg_index,
  input  logic [tqle_pkg::FR_W-1:0]             cfg_data
);
  import tqle_pkg::*;

  state_t state_r, state_nxt;

  logic [FR_W-1:0] disc_r, lr_init_r, decay_r, eps_init_r, eps_fin_r;
  logic [AU_W-1:0] actions_r;

  cmd_t                  cmd_r;
  logic [STATE_W-1:0]    s_r;
  logic [ACT_W-1:0]      act_r;
  logic signed [Q_W-1:0] reward_r;
  logic [STATE_W-1:0]    ns_r;
  logic [U_W-1:0]        u_r;
  logic [RACT_W-1:0]     ract_r;
  logic [CNT_W-1:0]      n_r;

  logic [ADDR_W-1:0]     clr_addr_r;
  logic [CNT_W-1:0]      col_r;
  logic                  scan_vld_r;
  logic [ACT_W-1:0]      scan_col_r;

  logic                  out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [OUT_TUSER_W-1:0] out_tuser_r;

  logic                  accept;
  logic                  scan_last;
  logic                  out_load;
  logic                  act_ok;
  logic                  explore;
  logic [STATE_W-1:0]    scan_row;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [Q_W-1:0]        ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [Q_W-1:0]        ram_rdata;

  logic signed [Q_W-1:0] best;
  logic [ACT_W-1:0]      best_col;
  arith_ctrl_t           actl;
  logic [FR_W-1:0]       eps_now;
  logic [FR_W-1:0]       lr_now;
  logic signed [Q_W-1:0] new_q;
  logic                  sat;

  logic [ACT_W-1:0]      chosen;
  logic signed [Q_W-1:0] row_max_v;
  logic signed [Q_W-1:0] new_q_v;
  logic                  sat_v;

  assign accept    = in_tvalid && in_tready;
  assign scan_last = (col_r + CNT_W'(1)) == n_r;
  assign out_load  = (state_r == S_OUT) && (!out_tvalid_r || out_tready);
  assign act_ok    = CNT_W'(act_r) < n_r;
  assign explore   = {1'b0, u_r} < eps_now;
  assign scan_row  = (cmd_r == CMD_UPDATE) ? ns_r : s_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_tuser))
            CMD_UPDATE, CMD_CHOOSE: state_nxt = S_SCAN;
            CMD_DECAY:              state_nxt = S_DEC_MUL;
            default:                state_nxt = S_OUT;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = (cmd_r == CMD_UPDATE) ? S_OLD : S_SETTLE;
        end
      end
      S_SETTLE:  state_nxt = S_OUT;
      S_OLD:     state_nxt = S_MUL_D;
      S_MUL_D:   state_nxt = S_TGT;
      S_TGT:     state_nxt = S_MUL_L;
      S_MUL_L:   state_nxt = S_SUM;
      S_SUM:     state_nxt = S_OUT;
      S_DEC_MUL: state_nxt = S_DEC_ADD;
      S_DEC_ADD: state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = {s_r, act_r};
    ram_wdata = new_q;
    ram_raddr = {scan_row, col_r[ACT_W-1:0]};
    actl      = '0;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      S_IDLE: begin
        in_tready    = 1'b1;
        actl.restart = accept && (cmd_t'(in_tuser) == CMD_RESTART);
      end
      S_OLD:     ram_raddr    = {s_r, act_r};
      S_MUL_D:   actl.ld_disc = 1'b1;
      S_TGT:     actl.ld_tgt  = 1'b1;
      S_MUL_L:   actl.ld_mul  = 1'b1;
      S_SUM:     actl.ld_sum  = 1'b1;
      S_DEC_MUL: actl.dec_mul = 1'b1;
      S_DEC_ADD: actl.dec_add = 1'b1;
      S_OUT:     ram_we       = out_load && (cmd_r == CMD_UPDATE) && act_ok;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      col_r        <= '0;
      scan_vld_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_vld_r <= (state_r == S_SCAN);
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (state_r == S_SCAN) begin
        col_r <= col_r + CNT_W'(1);
      end else begin
        col_r <= '0;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disc_r     <= RST_DISCOUNT;
      lr_init_r  <= RST_LR_INIT;
      decay_r    <= RST_DECAY;
      eps_init_r <= RST_EPS_INIT;
      eps_fin_r  <= RST_EPS_FIN;
      actions_r  <= RST_ACTIONS;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DISCOUNT: disc_r     <= cfg_data;
        CFG_LR_INIT:  lr_init_r  <= cfg_data;
        CFG_DECAY:    decay_r    <= cfg_data;
        CFG_EPS_INIT: eps_init_r <= cfg_data;
        CFG_EPS_FIN:  eps_fin_r  <= cfg_data;
        CFG_ACTIONS:  actions_r  <= cfg_data[AU_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    scan_col_r <= col_r[ACT_W-1:0];
    if (accept) begin
      cmd_r    <= cmd_t'(in_tuser);
      s_r      <= in_tdata[STATE_W-1:0];
      act_r    <= in_tdata[SIDX_W +: ACT_W];
      reward_r <= $signed(in_tdata[SIDX_W+AIDX_W +: Q_W]);
      ns_r     <= in_tdata[SIDX_W+AIDX_W+Q_W +: STATE_W];
      u_r      <= in_tdata[2*SIDX_W+AIDX_W+Q_W +: U_W];
      ract_r   <= in_tdata[2*SIDX_W+AIDX_W+Q_W+U_W +: RACT_W];
      n_r      <= used_actions(actions_r);
    end
  end

  always_comb begin
    chosen    = '0;
    row_max_v = '0;
    new_q_v   = '0;
    sat_v     = 1'b0;
    case (cmd_r)
      CMD_UPDATE: begin
        row_max_v = best;
        new_q_v   = act_ok ? new_q : '0;
        sat_v     = act_ok && sat;
      end
      CMD_CHOOSE: begin
        row_max_v = best;
        chosen    = explore ? mod_action(ract_r, n_r) : best_col;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {{(OUT_TDATA_W-2*Q_W-AIDX_W){1'b0}}, new_q_v, row_max_v,
                      AIDX_W'(chosen)};
      out_tuser_r <= {sat_v, (cmd_r == CMD_CHOOSE) && explore};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  tqle_ram #(
    .WIDTH (Q_W),
    .DEPTH (DEPTH)
  ) u_qtab (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tqle_scan u_scan (
    .clk      (clk),
    .vld      (scan_vld_r),
    .col      (scan_col_r),
    .rdata    ($signed(ram_rdata)),
    .best     (best),
    .best_col (best_col)
  );

  tqle_arith u_arith (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (actl),
    .discount  (frac(disc_r)),
    .lr_init   (frac(lr_init_r)),
    .decay     (frac(decay_r)),
    .eps_init  (frac(eps_init_r)),
    .eps_final (frac(eps_fin_r)),
    .best      (best),
    .old_q     ($signed(ram_rdata)),
    .reward    (reward_r),
    .eps_now   (eps_now),
    .lr_now    (lr_now),
    .new_q     (new_q),
    .sat       (sat)
  );

  a_ram_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_OUT))
    else $error("Q table written outside the clearing pass or result stage.");

  a_eps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    eps_now <= ONE_Q16)
    else $error("Epsilon rose above one.");

  a_lr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lr_now <= ONE_Q16)
    else $error("Learning rate rose above one.");

  a_sum_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SUM |=> (state_r == S_OUT && ram_we == 1'b0) || out_load)
    else $error("Update result did not reach the output stage.");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid_r)
    else $error("Loaded result not presented on the output.");

endmodule

/* sim/tb_tabular_q_learning_engine_unit.sv */
`timescale 1ns / 100ps
// Testbench for tabular_q_learning_engine_unit: a directed request table, then random phases
// under several register settings and stall patterns, each result checked against a Q table
// predictor in the bench, or typed rows' own values. Depends on tqle_pkg and the engine RTL.
module tb_tabular_q_learning_engine_unit;
  import tqle_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int PHASE_ITEMS    = 150;
  localparam int RAND_PHASES    = 8;
  localparam int TAIL_CYCLES    = 20;

  typedef struct {
    cmd_t                     cmd;
    logic [SIDX_W-1:0]        state;
    logic [AIDX_W-1:0]        act;
    logic signed [Q_W-1:0]    reward;
    logic [SIDX_W-1:0]        next_row;
    logic [U_W-1:0]           u;
    logic [RACT_W-1:0]        ract;
  } request_t;

  typedef struct {
    logic [ACT_W-1:0]         chosen;
    logic signed [Q_W-1:0]    peak;
    logic signed [Q_W-1:0]    new_q;
    logic                     explored;
    logic                     saturated;
  } reply_t;

  typedef struct {
    cmd_t                     cmd;
    logic [SIDX_W-1:0]        state;
    logic [AIDX_W-1:0]        act;
    logic [Q_W-1:0]           reward;
    logic [SIDX_W-1:0]        next_row;
    logic [U_W-1:0]           u;
    logic [RACT_W-1:0]        ract;
    bit                       typed;
    logic [ACT_W-1:0]         w_chosen;
    logic [Q_W-1:0]           w_peak;
    logic [Q_W-1:0]           w_new_q;
    bit                       w_explored;
    bit                       w_saturated;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [CMD_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [FR_W-1:0] cfg_data = '0;

  tabular_q_learning_engine_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int     q_table [DEPTH];
  longint eps_now      = longint'(RST_EPS_INIT);
  longint lr_now       = longint'(RST_LR_INIT);
  longint reg_disc     = longint'(RST_DISCOUNT);
  longint reg_lr_init  = longint'(RST_LR_INIT);
  longint reg_decay    = longint'(RST_DECAY);
  longint reg_eps_init = longint'(RST_EPS_INIT);
  longint reg_eps_fin  = longint'(RST_EPS_FIN);
  int     reg_actions  = int'(RST_ACTIONS);

  reply_t pending_replies[$];
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_req = 0;
  int quiet_cycles = 0;
  int n_cmd [4] = '{0, 0, 0, 0};
  int n_results = 0;
  int n_sat = 0;
  int n_expl = 0;
  int n_settings = 1;
  logic [SIDX_W-1:0] hot_rows [8];

  dir_row_t directed [19] = '{
    '{CMD_CHOOSE,  10'd0,    3'd0, 32'h00000000, 10'd0,    16'h0000, 3'd7,
      1'b1, 3'd7, 32'd0, 32'd0, 1'b1, 1'b0},
    '{CMD_CHOOSE,  10'd1023, 3'd0, 32'h00000000, 10'd0,    16'hFFFF, 3'd0,
      1'b1, 3'd0, 32'd0, 32'd0, 1'b1, 1'b0},
    '{CMD_UPDATE,  10'd0,    3'd0, 32'h00000000, 10'd1023, 16'h0000, 3'd0,
      1'b1, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    '{CMD_DECAY,   10'd0,    3'd0, 32'h00000000, 10'd0,    16'h0000, 3'd0,
      1'b1, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    '{CMD_RESTART, 10'd0,    3'd0, 32'h00000000, 10'd0,    16'h0000, 3'd0,
      1'b1, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    '{CMD_UPDATE,  10'd3,    3'd7, 32'h7FFFFFFF, 10'd3,    16'h0000, 3'd0,
      1'b0, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    '{CMD_UPDATE,  10'd3,    3'd0, 32'h80000000, 10'd3,    16'hFFFF, 3'd7,
      1'b0, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    '{CMD_CHOOSE,  10'd3,    3'd0, 32'h00000000, 10'd0,    16'h8000, 3'd5,
      1'b0, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    '{CMD_UPDATE,  10'd1023, 3'd3, 32'h00010000, 10'd1023, 16'h0000, 3'd0,
      1'b0, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    '{CMD_UPDATE,  10'd1023, 3'd3, 32'h00010000, 10'd1023, 16'h0000, 3'd0,
      1'b0, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    '{CMD_DECAY,   10'd0,    3'd0, 32'h00000000, 10'd0,    16'h0000, 3'd0,
      1'b1, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    '{CMD_UPDATE,  10'd512,  3'd5, 32'hFFFFFFFF, 10'd3,    16'h0000, 3'd0,
      1'b0, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    '{CMD_CHOOSE,  10'd1023, 3'd0, 32'h00000000, 10'd0,    16'hFFFF, 3'd6,
      1'b0, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    '{CMD_UPDATE,  10'd7,    3'd1, 32'h40000000, 10'd1023, 16'hFFFF, 3'd7,
      1'b0, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    '{CMD_CHOOSE,  10'd7,    3'd0, 32'h00000000, 10'd0,    16'h5555, 3'd2,
      1'b0, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    '{CMD_UPDATE,  10'h2AA,  3'd2, 32'h55555555, 10'h155,  16'h0000, 3'd0,
      1'b0, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    '{CMD_UPDATE,  10'h155,  3'd5, 32'hAAAAAAAA, 10'h2AA,  16'hAAAA, 3'd5,
      1'b0, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    '{CMD_CHOOSE,  10'h2AA,  3'd0, 32'h00000000, 10'd0,    16'hAAAA, 3'd5,
      1'b0, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0},
    '{CMD_RESTART, 10'd0,    3'd0, 32'h00000000, 10'd0,    16'h0000, 3'd0,
      1'b1, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0}
  };

  function automatic longint cap_one(longint v);
    return (v > 65536) ? 64'sd65536 : v;
  endfunction

  function automatic int actions_in_use();
    if (reg_actions == 0) return 1;
    if (reg_actions > NUM_ACTIONS) return NUM_ACTIONS;
    return reg_actions;
  endfunction

  // Divide by 65536 rounding to nearest, ties toward plus infinity.
  function automatic longint round_shift16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint row_peak(int row, output int col);
    longint best;
    int n;
    n = actions_in_use();
    best = q_table[row * NUM_ACTIONS];
    col = 0;
    for (int c = 1; c < n; c++) begin
      if (q_table[row * NUM_ACTIONS + c] > best) begin
        best = q_table[row * NUM_ACTIONS + c];
        col = c;
      end
    end
    return best;
  endfunction

  function automatic reply_t compute_reply(request_t rq);
    reply_t rp;
    longint m, lrv, old, tgt, v, f, fin, e;
    int col, idx;
    rp = '{default: '0};
    case (rq.cmd)
      CMD_UPDATE: begin
        m = row_peak(int'(rq.next_row), col);
        rp.peak = m[31:0];
        if (int'(rq.act) < actions_in_use()) begin
          idx = int'(rq.state) * NUM_ACTIONS + int'(rq.act);
          lrv = cap_one(lr_now);
          old = q_table[idx];
          tgt = longint'(rq.reward) + round_shift16(cap_one(reg_disc) * m);
          v = round_shift16((65536 - lrv) * old + lrv * tgt);
          if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
            rp.saturated = 1'b1;
          end else if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
            rp.saturated = 1'b1;
          end
          q_table[idx] = int'(v);
          rp.new_q = v[31:0];
        end
      end
      CMD_CHOOSE: begin
        m = row_peak(int'(rq.state), col);
        rp.peak = m[31:0];
        if (longint'(rq.u) < cap_one(eps_now)) begin
          rp.chosen = 3'(int'(rq.ract) % actions_in_use());
          rp.explored = 1'b1;
        end else begin
          rp.chosen = 3'(col);
        end
      end
      CMD_DECAY: begin
        f = 65536 - cap_one(reg_decay);
        fin = cap_one(reg_eps_fin);
        e = cap_one(eps_now);
        eps_now = fin + round_shift16(f * (e - fin));
        lr_now = round_shift16(f * cap_one(lr_now));
      end
      default: begin
        eps_now = cap_one(reg_eps_init);
        lr_now = cap_one(reg_lr_init);
      end
    endcase
    return rp;
  endfunction

  function automatic logic [SIDX_W-1:0] pick_row();
    if ($urandom_range(0, 99) < 80) return hot_rows[$urandom_range(0, 7)];
    return SIDX_W'($urandom);
  endfunction

  function automatic request_t random_request();
    request_t rq;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) rq.cmd = CMD_UPDATE;
    else if (sel < 85) rq.cmd = CMD_CHOOSE;
    else if (sel < 93) rq.cmd = CMD_DECAY;
    else rq.cmd = CMD_RESTART;
    rq.state = pick_row();
    rq.next_row = pick_row();
    rq.act = AIDX_W'($urandom);
    rq.u = U_W'($urandom);
    rq.ract = RACT_W'($urandom);
    case ($urandom_range(0, 7))
      0: rq.reward = 32'sh7FFFFFFF;
      1: rq.reward = 32'sh80000000;
      2: rq.reward = $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      3, 4: rq.reward = int'($urandom_range(0, 524288)) - 262144;
      default: rq.reward = $urandom;
    endcase
    return rq;
  endfunction

  function automatic logic [FR_W-1:0] random_fraction();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ONE_Q16;
      2: return FR_W'($urandom_range(65537, 131071));
      default: return FR_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic send_item(request_t rq, bit typed, reply_t typed_reply);
    reply_t rp;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, rq.ract, rq.u, rq.next_row, rq.reward, rq.act, rq.state};
    in_tuser <= rq.cmd;
    do @(posedge clk); while (!in_tready);
    rp = compute_reply(rq);
    if (typed) rp = typed_reply;
    pending_replies.push_back(rp);
    n_cmd[int'(rq.cmd)]++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [FR_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_DISCOUNT: reg_disc = longint'(val);
      CFG_LR_INIT:  reg_lr_init = longint'(val);
      CFG_DECAY:    reg_decay = longint'(val);
      CFG_EPS_INIT: reg_eps_init = longint'(val);
      CFG_EPS_FIN:  reg_eps_fin = longint'(val);
      default:      reg_actions = int'(val[AU_W-1:0]);
    endcase
  endtask

  task automatic apply_settings(logic [FR_W-1:0] disc, logic [FR_W-1:0] lr,
                                logic [FR_W-1:0] dec, logic [FR_W-1:0] ei,
                                logic [FR_W-1:0] ef, logic [FR_W-1:0] au);
    write_reg(CFG_DISCOUNT, disc);
    write_reg(CFG_LR_INIT, lr);
    write_reg(CFG_DECAY, dec);
    write_reg(CFG_EPS_INIT, ei);
    write_reg(CFG_EPS_FIN, ef);
    write_reg(CFG_ACTIONS, au);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    int hold_left;
    reply_t want, got;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.chosen = out_tdata[2:0];
        got.peak = out_tdata[34:3];
        got.new_q = out_tdata[66:35];
        got.explored = out_tuser[0];
        got.saturated = out_tuser[1];
        n_results++;
        if (got.saturated) n_sat++;
        if (got.explored) n_expl++;
        if (pending_replies.size() == 0) begin
          $display("%0t ns: result with no request pending, actual peak %0d", $time,
                   longint'(got.peak));
          errors++;
        end else begin
          want = pending_replies.pop_front();
          check_field("chosen_action", want.chosen, got.chosen);
          check_field("row_max", longint'(want.peak), longint'(got.peak));
          check_field("new_q", longint'(want.new_q), longint'(got.new_q));
          check_field("explored", want.explored, got.explored);
          check_field("saturated", want.saturated, got.saturated);
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: timeout, nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    request_t rq;
    reply_t tr;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      rq.cmd = directed[i].cmd;
      rq.state = directed[i].state;
      rq.act = directed[i].act;
      rq.reward = directed[i].reward;
      rq.next_row = directed[i].next_row;
      rq.u = directed[i].u;
      rq.ract = directed[i].ract;
      tr.chosen = directed[i].w_chosen;
      tr.peak = directed[i].w_peak;
      tr.new_q = directed[i].w_new_q;
      tr.explored = directed[i].w_explored;
      tr.saturated = directed[i].w_saturated;
      send_item(rq, directed[i].typed, tr);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_drained();
      case (p)
        0: apply_settings(ONE_Q16, ONE_Q16, '0, '0, '0, FR_W'(8));
        1: apply_settings('0, '0, ONE_Q16, ONE_Q16, ONE_Q16, FR_W'(1));
        2: apply_settings('1, '1, '1, '1, '1, FR_W'(15));
        3: apply_settings(FR_W'(32768), FR_W'(40000), FR_W'(8192), FR_W'(1000),
                          FR_W'(50000), FR_W'(0));
        default: apply_settings(random_fraction(), random_fraction(), random_fraction(),
                                random_fraction(), random_fraction(),
                                $urandom_range(0, 3) ? FR_W'($urandom_range(1, 8))
                                                     : FR_W'($urandom_range(0, 15)));
      endcase
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 71; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 71; end
        default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
      endcase
      hot_rows[0] = '0;
      hot_rows[1] = '1;
      for (int h = 2; h < 8; h++) hot_rows[h] = SIDX_W'($urandom);
      rq = random_request();
      rq.cmd = CMD_RESTART;
      send_item(rq, 1'b0, tr);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Back pressure: the output holds off while requests keep coming, and
        // later the input pauses until the engine has drained.
        if (p == 4 && i == 50) hold_req = 300;
        if (p == 4 && i == 100) wait_drained();
        send_item(random_request(), 1'b0, tr);
      end
    end

    wait_drained();
    $display("Sent %0d updates, %0d chooses, %0d decays, %0d restarts under %0d settings.",
             n_cmd[0], n_cmd[1], n_cmd[2], n_cmd[3], n_settings);
    $display("Checked %0d results: %0d saturated updates, %0d explored choices.",
             n_results, n_sat, n_expl);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/tqle_pkg.sv
hdl/tqle_ram.sv
hdl/tqle_scan.sv
hdl/tqle_arith.sv
hdl/tabular_q_learning_engine_unit.sv
sim/tb_tabular_q_learning_engine_unit.sv
